FILE: rtl/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int PAGE_BITS  = 12;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int PROBE_MAX  = 2 * SLOT_COUNT - 1;
    localparam int PROBE_W    = $clog2(2 * SLOT_COUNT);
    localparam int HI_W       = 32 - PAGE_BITS;
    localparam int CFG_IDX_W  = 1;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_FLAGS = 1'd1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] phys_addr;
        logic [31:0] virt_addr_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] virt_addr_out;
        logic [9:0]  slot;
        logic [31:0] entry_value;
        logic        flushed;
    } rsp_t;

    typedef struct packed {
        logic in_use;
        logic ready;
    } slot_state_t;

    typedef struct packed {
        logic advance;
        logic reclaim;
    } cell_ctl_t;

    typedef struct packed {
        logic              advance;
        logic              reclaim;
        logic              claim;
        logic              mark_en;
        logic [SLOT_W-1:0] mark_pos;
    } ring_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/temp_page_map_slot_allocator.sv
// Channel   Ports                           Handshake
// request   start, busy, req                taken when start && !busy
// result    done, rsp                       valid for one cycle when done
// config    cfg_we, cfg_index, cfg_wdata    written when cfg_we
//
// A map is accepted and then probes the slot ring; the ring rotates one slot per
// cycle while a map probes, up to 2 * SLOT_COUNT probes when full.
// An unmap needs no probe. The result shows in the cycle after the last step.
// Reset clears every slot, the cursor and both registers at once.
// The receiver cannot stall; busy is the only back-pressure on requests.
`default_nettype none

module temp_page_map_slot_allocator
    import tpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire req_t                 req,
    output logic                      done,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_UNMAP = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] cursor_reg, cursor_next;
    logic [PROBE_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic              wrapped_reg, wrapped_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;
    req_t              req_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              in_range_reg;
    logic [31:0]       window_base_reg;
    logic [11:0]       entry_flags_reg;

    logic [31:0]       diff;
    logic [HI_W-1:0]   diff_hi;
    logic              accept;
    logic              wrap;
    logic              free;
    logic [SLOT_W-1:0] cursor_adv;
    logic [SLOT_W:0]   pos_sum;
    logic [31:0]       idx32;
    logic [31:0]       page_va;
    slot_state_t       probe;
    ring_ctl_t         ring_ctl;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign diff    = req.virt_addr_in - window_base_reg;
    assign diff_hi = diff[31:PAGE_BITS];

    assign wrap       = (cursor_reg == SLOT_W'(SLOT_COUNT - 1));
    assign cursor_adv = wrap ? '0 : cursor_reg + SLOT_W'(1);
    assign free       = wrap ? (!probe.in_use || probe.ready)
                             : (!probe.in_use && !probe.ready);

    always_comb
    begin
        pos_sum = (SLOT_W+1)'(idx_reg) - (SLOT_W+1)'(cursor_reg);
        if (idx_reg < cursor_reg)
        begin
            pos_sum = pos_sum + (SLOT_W+1)'(SLOT_COUNT);
        end
    end

    assign idx32   = 32'(cursor_adv);
    assign page_va = (idx32 << PAGE_BITS) | {{(32-PAGE_BITS){1'b0}},
                                             req_reg.phys_addr[PAGE_BITS-1:0]};

    assign ring_ctl.advance  = (state_reg == ST_PROBE);
    assign ring_ctl.reclaim  = (state_reg == ST_PROBE) && wrap;
    assign ring_ctl.claim    = (state_reg == ST_PROBE) && free;
    assign ring_ctl.mark_en  = (state_reg == ST_UNMAP) && in_range_reg;
    assign ring_ctl.mark_pos = pos_sum[SLOT_W-1:0];

    tpm_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .probe (probe)
    );

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        probe_cnt_next = probe_cnt_reg;
        wrapped_next   = wrapped_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    probe_cnt_next = '0;
                    wrapped_next   = 1'b0;
                    state_next     = (req.opcode == OP_UNMAP) ? ST_UNMAP : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cursor_next    = cursor_adv;
                probe_cnt_next = probe_cnt_reg + PROBE_W'(1);
                wrapped_next   = wrapped_reg || wrap;
                if (free)
                begin
                    rsp_next.status        = STATUS_OK;
                    rsp_next.virt_addr_out = window_base_reg + page_va;
                    rsp_next.slot          = idx32[9:0];
                    rsp_next.entry_value   = {req_reg.phys_addr[31:PAGE_BITS],
                                              {PAGE_BITS{1'b0}}}
                                             | 32'(entry_flags_reg);
                    rsp_next.flushed       = wrapped_reg || wrap;
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
                else if (probe_cnt_reg == PROBE_W'(PROBE_MAX))
                begin
                    rsp_next         = '0;
                    rsp_next.status  = STATUS_FULL;
                    rsp_next.flushed = wrapped_reg || wrap;
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_UNMAP:
            begin
                rsp_next = '0;
                if (in_range_reg)
                begin
                    rsp_next.status = STATUS_OK;
                    rsp_next.slot   = 10'(32'(idx_reg));
                end
                else
                begin
                    rsp_next.status = STATUS_RANGE;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cursor_reg      <= '0;
            probe_cnt_reg   <= '0;
            wrapped_reg     <= 1'b0;
            done_reg        <= 1'b0;
            window_base_reg <= '0;
            entry_flags_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            probe_cnt_reg <= probe_cnt_next;
            wrapped_reg   <= wrapped_next;
            done_reg      <= done_next;
            if (cfg_we && (cfg_index == REG_WINDOW_BASE))
            begin
                window_base_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_ENTRY_FLAGS))
            begin
                entry_flags_reg <= cfg_wdata[11:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg      <= req;
            idx_reg      <= diff_hi[SLOT_W-1:0];
            in_range_reg <= (diff_hi < HI_W'(SLOT_COUNT));
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in work");

    a_full_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_FULL) |-> rsp.flushed)
        else $error("full result without a reclaim pass");

    a_cursor_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(cursor_reg))
        else $error("cursor moved while idle");

    a_unmap_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNMAP) |=> (done && state_reg == ST_IDLE))
        else $error("unmap did not finish in one cycle");

endmodule

`default_nettype wire

FILE: rtl/tpm_cell.sv
`default_nettype none

module tpm_cell
    import tpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_ctl_t   ctl,
    input  wire slot_state_t nb,
    input  wire logic        claim,
    input  wire logic        mark,
    output slot_state_t      state
);

    slot_state_t state_reg;
    slot_state_t state_next;

    always_comb
    begin
        state_next = ctl.advance ? nb : state_reg;
        if (ctl.reclaim && state_next.ready)
        begin
            state_next = '0;
        end
        if (claim)
        begin
            state_next.in_use = 1'b1;
        end
        if (mark)
        begin
            state_next.ready = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

FILE: rtl/tpm_ring.sv
`default_nettype none

module tpm_ring
    import tpm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ring_ctl_t ctl,
    output slot_state_t    probe
);

    slot_state_t cells [SLOT_COUNT];
    cell_ctl_t   cell_ctl;

    assign cell_ctl.advance = ctl.advance;
    assign cell_ctl.reclaim = ctl.reclaim;

    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_cell
        localparam int NB = (k + 1) % SLOT_COUNT;
        logic claim_k;
        logic mark_k;

        assign claim_k = (k == 0) ? ctl.claim : 1'b0;
        assign mark_k  = ctl.mark_en && (ctl.mark_pos == SLOT_W'(k));

        tpm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl),
            .nb    (cells[NB]),
            .claim (claim_k),
            .mark  (mark_k),
            .state (cells[k])
        );
    end

    // cell 0 holds the cursor slot, cell 1 the next one to probe
    assign probe = cells[1];

endmodule

`default_nettype wire
